[hw/rtl/mvds_pkg.sv]
`timescale 1ns / 1ps

package mvds_pkg;

  // field widths
  localparam int POS_WIDTH = 32;
  localparam int COV_WIDTH = 32;
  localparam int SIGW      = 32;

  // operation codes
  localparam logic [1:0] OP_PRI = 2'd0;
  localparam logic [1:0] OP_JET = 2'd1;
  localparam logic [1:0] OP_SEC = 2'd2;

  // internal widths
  localparam int DW     = POS_WIDTH + 1;          // offset d
  localparam int CW     = COV_WIDTH + 1;          // summed covariance
  localparam int AW     = 2 * CW + 1;             // adjugate entry
  localparam int TW     = 2 * DW;                 // d_i * d_j
  localparam int DETW   = CW + AW + 2;            // determinant
  localparam int XW     = (AW > DW) ? AW : DW;    // multiplier x operand
  localparam int YW     = (TW > CW) ? TW : CW;    // multiplier y operand
  localparam int SMALLW = (CW > DW) ? CW : DW;    // serial length for c, d, jet
  localparam int PRW    = XW + YW;                // product
  localparam int ACCW   = PRW + 3;                // accumulator
  localparam int FRAC   = 24;                     // scale of the quotient
  localparam int SW     = SIGW - 1;               // significance magnitude bits
  localparam int QW     = 2 * SW;                 // saturated quotient bits
  localparam int NUMW   = ACCW + FRAC;
  localparam int RW     = ((NUMW > DETW + QW) ? NUMW : DETW + QW) + 1;
  localparam int NBW    = $clog2(YW + 1);

  // sequencer program
  localparam int NSTEPS = 30;
  localparam int STEPW  = 5;

  typedef enum logic [3:0] {
    X_C0, X_C1, X_C2, X_C3, X_C4, X_C5,
    X_D0, X_D1, X_D2,
    X_A00, X_A11, X_A22, X_A01, X_A02, X_A12
  } x_src_e;

  typedef enum logic [3:0] {
    Y_C0, Y_C1, Y_C2, Y_C3, Y_C4, Y_C5,
    Y_D0, Y_D1, Y_D2,
    Y_J0, Y_J1, Y_J2,
    Y_T
  } y_src_e;

  typedef enum logic [2:0] {
    ACC_T, ACC_CLR, ACC_ADD, ACC_SUB, ACC_ADD2
  } acc_op_e;

  typedef enum logic [3:0] {
    DST_NONE, DST_DOT, DST_A00, DST_A11, DST_A22, DST_A01, DST_A02, DST_A12, DST_DET
  } dest_e;

  typedef struct packed {
    x_src_e  xs;
    y_src_e  ys;
    acc_op_e op;
    dest_e   dst;
  } step_t;

  localparam logic [STEPW-1:0] LAST_STEP = STEPW'(NSTEPS - 1);

  // multiply-accumulate program: jet dot, adjugate, determinant, quadratic form
  function automatic step_t step_entry(input logic [STEPW-1:0] idx);
    step_t s;
    s = '{X_C0, Y_C0, ACC_T, DST_NONE};
    unique case (idx)
      5'd0:  s = '{X_D0,  Y_J0, ACC_CLR,  DST_NONE};
      5'd1:  s = '{X_D1,  Y_J1, ACC_ADD,  DST_NONE};
      5'd2:  s = '{X_D2,  Y_J2, ACC_ADD,  DST_DOT};
      5'd3:  s = '{X_C3,  Y_C5, ACC_CLR,  DST_NONE};
      5'd4:  s = '{X_C4,  Y_C4, ACC_SUB,  DST_A00};
      5'd5:  s = '{X_C0,  Y_C5, ACC_CLR,  DST_NONE};
      5'd6:  s = '{X_C2,  Y_C2, ACC_SUB,  DST_A11};
      5'd7:  s = '{X_C0,  Y_C3, ACC_CLR,  DST_NONE};
      5'd8:  s = '{X_C1,  Y_C1, ACC_SUB,  DST_A22};
      5'd9:  s = '{X_C2,  Y_C4, ACC_CLR,  DST_NONE};
      5'd10: s = '{X_C1,  Y_C5, ACC_SUB,  DST_A01};
      5'd11: s = '{X_C1,  Y_C4, ACC_CLR,  DST_NONE};
      5'd12: s = '{X_C2,  Y_C3, ACC_SUB,  DST_A02};
      5'd13: s = '{X_C1,  Y_C2, ACC_CLR,  DST_NONE};
      5'd14: s = '{X_C0,  Y_C4, ACC_SUB,  DST_A12};
      5'd15: s = '{X_A00, Y_C0, ACC_CLR,  DST_NONE};
      5'd16: s = '{X_A01, Y_C1, ACC_ADD,  DST_NONE};
      5'd17: s = '{X_A02, Y_C2, ACC_ADD,  DST_DET};
      5'd18: s = '{X_D0,  Y_D0, ACC_T,    DST_NONE};
      5'd19: s = '{X_A00, Y_T,  ACC_CLR,  DST_NONE};
      5'd20: s = '{X_D1,  Y_D1, ACC_T,    DST_NONE};
      5'd21: s = '{X_A11, Y_T,  ACC_ADD,  DST_NONE};
      5'd22: s = '{X_D2,  Y_D2, ACC_T,    DST_NONE};
      5'd23: s = '{X_A22, Y_T,  ACC_ADD,  DST_NONE};
      5'd24: s = '{X_D0,  Y_D1, ACC_T,    DST_NONE};
      5'd25: s = '{X_A01, Y_T,  ACC_ADD2, DST_NONE};
      5'd26: s = '{X_D0,  Y_D2, ACC_T,    DST_NONE};
      5'd27: s = '{X_A02, Y_T,  ACC_ADD2, DST_NONE};
      5'd28: s = '{X_D1,  Y_D2, ACC_T,    DST_NONE};
      5'd29: s = '{X_A12, Y_T,  ACC_ADD2, DST_NONE};
      default: s = '{X_C0, Y_C0, ACC_T, DST_NONE};
    endcase
    return s;
  endfunction

endpackage

[hw/rtl/mvds_mul.sv]
`timescale 1ns / 1ps

module mvds_mul (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [mvds_pkg::XW-1:0]      x_i,
  input  logic signed [mvds_pkg::YW-1:0]      y_i,
  input  logic        [mvds_pkg::NBW-1:0]     nbits_i,
  output logic                                done_o,
  output logic signed [mvds_pkg::PRW-1:0]     p_o
);

  logic                          busy_q, done_q, neg_q;
  logic [mvds_pkg::NBW-1:0]      cnt_q;
  logic [mvds_pkg::PRW-1:0]      mx_q, prod_q;
  logic [mvds_pkg::YW-1:0]       my_q;
  logic [mvds_pkg::XW-1:0]       x_mag;
  logic [mvds_pkg::YW-1:0]       y_mag;

  // operand magnitudes
  assign x_mag = x_i[mvds_pkg::XW-1] ? mvds_pkg::XW'(-x_i) : mvds_pkg::XW'(x_i);
  assign y_mag = y_i[mvds_pkg::YW-1] ? mvds_pkg::YW'(-y_i) : mvds_pkg::YW'(y_i);

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= nbits_i;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == mvds_pkg::NBW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift-add datapath, one multiplier bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mx_q   <= mvds_pkg::PRW'(x_mag);
      my_q   <= y_mag;
      prod_q <= '0;
      neg_q  <= x_i[mvds_pkg::XW-1] ^ y_i[mvds_pkg::YW-1];
    end else if (busy_q) begin
      if (my_q[0]) begin
        prod_q <= prod_q + mx_q;
      end
      mx_q <= mx_q << 1;
      my_q <= my_q >> 1;
    end
  end

  assign done_o = done_q;
  assign p_o    = neg_q ? -$signed(prod_q) : $signed(prod_q);

endmodule

[hw/rtl/mvds_root.sv]
`timescale 1ns / 1ps

module mvds_root (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [mvds_pkg::ACCW-1:0]      num_i,
  input  logic [mvds_pkg::DETW-1:0]      den_i,
  output logic                           done_o,
  output logic [mvds_pkg::SW-1:0]        root_o
);

  localparam int CNTW = $clog2(mvds_pkg::QW + 1);

  typedef enum logic [1:0] {R_IDLE, R_CHK, R_DIV, R_SQRT} rstate_e;

  rstate_e                  state_q;
  logic                     done_q;
  logic [CNTW-1:0]          cnt_q;
  logic [mvds_pkg::RW-1:0]  rem_q, dv_q;
  logic [mvds_pkg::QW-1:0]  quo_q, res_q, one_q;
  logic                     ge;
  logic [mvds_pkg::QW-1:0]  trial;

  // remainder against divisor, shared by saturation check and division; trial root
  assign ge    = (rem_q >= dv_q);
  assign trial = res_q + one_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= R_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        R_IDLE: begin
          done_q <= 1'b0;
          if (start_i) begin
            state_q <= R_CHK;
          end
        end
        R_CHK: begin
          // quotient of 2^QW or more saturates
          if (ge) begin
            done_q  <= 1'b1;
            state_q <= R_IDLE;
          end else begin
            done_q  <= 1'b0;
            cnt_q   <= CNTW'(mvds_pkg::QW);
            state_q <= R_DIV;
          end
        end
        R_DIV: begin
          done_q <= 1'b0;
          if (cnt_q == CNTW'(1)) begin
            cnt_q   <= CNTW'(mvds_pkg::SW);
            state_q <= R_SQRT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        R_SQRT: begin
          cnt_q  <= cnt_q - 1'b1;
          done_q <= (cnt_q == CNTW'(1));
          if (cnt_q == CNTW'(1)) begin
            state_q <= R_IDLE;
          end
        end
        default: begin
          done_q  <= 1'b0;
          state_q <= R_IDLE;
        end
      endcase
    end
  end

  // restoring division, then digit-by-digit square root
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      R_IDLE: begin
        if (start_i) begin
          rem_q <= mvds_pkg::RW'(num_i) << mvds_pkg::FRAC;
          dv_q  <= mvds_pkg::RW'(den_i) << mvds_pkg::QW;
          quo_q <= '0;
        end
      end
      R_CHK: begin
        if (ge) begin
          res_q <= mvds_pkg::QW'({mvds_pkg::SW{1'b1}});
        end
        dv_q <= dv_q >> 1;
      end
      R_DIV: begin
        if (ge) begin
          rem_q <= rem_q - dv_q;
        end
        quo_q <= {quo_q[mvds_pkg::QW-2:0], ge};
        dv_q  <= dv_q >> 1;
        if (cnt_q == CNTW'(1)) begin
          res_q <= '0;
          one_q <= mvds_pkg::QW'(1) << (mvds_pkg::QW - 2);
        end
      end
      R_SQRT: begin
        if (quo_q >= trial) begin
          quo_q <= quo_q - trial;
          res_q <= (res_q >> 1) + one_q;
        end else begin
          res_q <= res_q >> 1;
        end
        one_q <= one_q >> 2;
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign root_o = res_q[mvds_pkg::SW-1:0];

endmodule

[hw/rtl/max_vertex_decay_significance.sv]
`timescale 1ns / 1ps

// Maximum signed 3D decay-length significance over a run of secondary vertices.
// Input channel (in_valid_i / in_stall_o): one transaction per item. Operation
// 0 loads the primary vertex, 1 the jet direction; neither stalls the input. Operation
// 2 is a secondary vertex: a sequencer runs 30 multiply-accumulate steps on one
// shift-add multiplier (one bit a cycle, 33 or 66 bits per step) and then, if
// the vertex passes its checks, a divide and square-root unit; in_stall_o stays
// high meanwhile. Unused operation code 3 is dropped.
// Output channel (out_valid_o / out_stall_i): one transaction on the vertex
// that carries last_i, holding the best significance of the run (Q19.12) and
// any_valid_o. The result sits in an output register; a new item is taken
// while it waits, and only a second result waits until the first is taken.
// The payload holds while out_stall_i is high.
// Reset clears primary vertex, jet direction and the running maximum.

module max_vertex_decay_significance (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic        [1:0]                      operation_i,
  input  logic signed [mvds_pkg::POS_WIDTH-1:0]  pos_x_i,
  input  logic signed [mvds_pkg::POS_WIDTH-1:0]  pos_y_i,
  input  logic signed [mvds_pkg::POS_WIDTH-1:0]  pos_z_i,
  input  logic signed [mvds_pkg::COV_WIDTH-1:0]  cov_xx_i,
  input  logic signed [mvds_pkg::COV_WIDTH-1:0]  cov_xy_i,
  input  logic signed [mvds_pkg::COV_WIDTH-1:0]  cov_xz_i,
  input  logic signed [mvds_pkg::COV_WIDTH-1:0]  cov_yy_i,
  input  logic signed [mvds_pkg::COV_WIDTH-1:0]  cov_yz_i,
  input  logic signed [mvds_pkg::COV_WIDTH-1:0]  cov_zz_i,
  input  logic                                   last_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [mvds_pkg::SIGW-1:0]       significance_o,
  output logic                                   any_valid_o
);

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_GO, S_MUL_WAIT, S_CHECK, S_ROOT_WAIT, S_FINISH
  } state_e;

  state_e                               state_q;
  logic [mvds_pkg::STEPW-1:0]           step_q;
  logic                                 last_q, pass_q, seen_q, out_valid_q, out_any_q;
  logic signed [mvds_pkg::SIGW-1:0]     best_q, sval_q, out_sig_q;

  // persistent event state
  logic signed [mvds_pkg::POS_WIDTH-1:0] ppx_q, ppy_q, ppz_q, jx_q, jy_q, jz_q;
  logic signed [mvds_pkg::COV_WIDTH-1:0] pcxx_q, pcxy_q, pcxz_q, pcyy_q, pcyz_q, pczz_q;

  // per-vertex working registers
  logic signed [mvds_pkg::DW-1:0]   d0_q, d1_q, d2_q;
  logic signed [mvds_pkg::CW-1:0]   c0_q, c1_q, c2_q, c3_q, c4_q, c5_q;
  logic signed [mvds_pkg::AW-1:0]   a00_q, a11_q, a22_q, a01_q, a02_q, a12_q;
  logic signed [mvds_pkg::DETW-1:0] det_q;
  logic signed [mvds_pkg::TW-1:0]   t_q;
  logic signed [mvds_pkg::ACCW-1:0] acc_q, acc_new, p_ext;
  logic                             dotneg_q;

  mvds_pkg::step_t                  stp;
  logic signed [mvds_pkg::XW-1:0]   mul_x;
  logic signed [mvds_pkg::YW-1:0]   mul_y;
  logic [mvds_pkg::NBW-1:0]         mul_nbits;
  logic                             mul_start, mul_done;
  logic signed [mvds_pkg::PRW-1:0]  mul_p;

  logic                             root_start, root_done;
  logic [mvds_pkg::SW-1:0]          root;
  logic [mvds_pkg::ACCW-1:0]        num;
  logic [mvds_pkg::DETW-1:0]        den;

  logic                             in_acc, det_neg, pass;
  logic                             best_upd, seen_new, out_load;
  logic signed [mvds_pkg::SIGW-1:0] best_new, sval;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // operand selection for the current program step
  assign stp = mvds_pkg::step_entry(step_q);

  always_comb begin
    unique case (stp.xs)
      mvds_pkg::X_C0:  mul_x = mvds_pkg::XW'(c0_q);
      mvds_pkg::X_C1:  mul_x = mvds_pkg::XW'(c1_q);
      mvds_pkg::X_C2:  mul_x = mvds_pkg::XW'(c2_q);
      mvds_pkg::X_C3:  mul_x = mvds_pkg::XW'(c3_q);
      mvds_pkg::X_C4:  mul_x = mvds_pkg::XW'(c4_q);
      mvds_pkg::X_C5:  mul_x = mvds_pkg::XW'(c5_q);
      mvds_pkg::X_D0:  mul_x = mvds_pkg::XW'(d0_q);
      mvds_pkg::X_D1:  mul_x = mvds_pkg::XW'(d1_q);
      mvds_pkg::X_D2:  mul_x = mvds_pkg::XW'(d2_q);
      mvds_pkg::X_A00: mul_x = mvds_pkg::XW'(a00_q);
      mvds_pkg::X_A11: mul_x = mvds_pkg::XW'(a11_q);
      mvds_pkg::X_A22: mul_x = mvds_pkg::XW'(a22_q);
      mvds_pkg::X_A01: mul_x = mvds_pkg::XW'(a01_q);
      mvds_pkg::X_A02: mul_x = mvds_pkg::XW'(a02_q);
      mvds_pkg::X_A12: mul_x = mvds_pkg::XW'(a12_q);
      default:         mul_x = '0;
    endcase
  end

  always_comb begin
    unique case (stp.ys)
      mvds_pkg::Y_C0: mul_y = mvds_pkg::YW'(c0_q);
      mvds_pkg::Y_C1: mul_y = mvds_pkg::YW'(c1_q);
      mvds_pkg::Y_C2: mul_y = mvds_pkg::YW'(c2_q);
      mvds_pkg::Y_C3: mul_y = mvds_pkg::YW'(c3_q);
      mvds_pkg::Y_C4: mul_y = mvds_pkg::YW'(c4_q);
      mvds_pkg::Y_C5: mul_y = mvds_pkg::YW'(c5_q);
      mvds_pkg::Y_D0: mul_y = mvds_pkg::YW'(d0_q);
      mvds_pkg::Y_D1: mul_y = mvds_pkg::YW'(d1_q);
      mvds_pkg::Y_D2: mul_y = mvds_pkg::YW'(d2_q);
      mvds_pkg::Y_J0: mul_y = mvds_pkg::YW'(jx_q);
      mvds_pkg::Y_J1: mul_y = mvds_pkg::YW'(jy_q);
      mvds_pkg::Y_J2: mul_y = mvds_pkg::YW'(jz_q);
      mvds_pkg::Y_T:  mul_y = mvds_pkg::YW'(t_q);
      default:        mul_y = '0;
    endcase
  end

  assign mul_nbits = (stp.ys == mvds_pkg::Y_T) ? mvds_pkg::NBW'(mvds_pkg::YW)
                                                : mvds_pkg::NBW'(mvds_pkg::SMALLW);
  assign mul_start = (state_q == S_MUL_GO);

  mvds_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .nbits_i (mul_nbits),
    .done_o  (mul_done),
    .p_o     (mul_p)
  );

  // accumulator update
  assign p_ext = mvds_pkg::ACCW'(mul_p);

  always_comb begin
    unique case (stp.op)
      mvds_pkg::ACC_T:    acc_new = acc_q;
      mvds_pkg::ACC_CLR:  acc_new = p_ext;
      mvds_pkg::ACC_ADD:  acc_new = acc_q + p_ext;
      mvds_pkg::ACC_SUB:  acc_new = acc_q - p_ext;
      mvds_pkg::ACC_ADD2: acc_new = acc_q + (p_ext <<< 1);
      default:            acc_new = acc_q;
    endcase
  end

  // vertex checks: determinant, inverse diagonals, quadratic form
  assign det_neg = det_q[mvds_pkg::DETW-1];
  assign pass = (det_q != '0)
             && (a00_q != '0) && (a00_q[mvds_pkg::AW-1] == det_neg)
             && (a11_q != '0) && (a11_q[mvds_pkg::AW-1] == det_neg)
             && (a22_q != '0) && (a22_q[mvds_pkg::AW-1] == det_neg)
             && (acc_q != '0) && (acc_q[mvds_pkg::ACCW-1] == det_neg);

  assign num = acc_q[mvds_pkg::ACCW-1] ? mvds_pkg::ACCW'(-acc_q) : mvds_pkg::ACCW'(acc_q);
  assign den = det_neg ? mvds_pkg::DETW'(-det_q) : mvds_pkg::DETW'(det_q);
  assign root_start = (state_q == S_CHECK) && pass;

  mvds_root u_root (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .num_i   (num),
    .den_i   (den),
    .done_o  (root_done),
    .root_o  (root)
  );

  assign sval = dotneg_q ? -$signed({1'b0, root}) : $signed({1'b0, root});

  // running maximum
  assign best_upd = pass_q && (!seen_q || (sval_q > best_q));
  assign best_new = best_upd ? sval_q : best_q;
  assign seen_new = seen_q || pass_q;

  // result enters the output register
  assign out_load = (state_q == S_FINISH) && last_q && (!out_valid_q || !out_stall_i);

  // sequencer, event state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      last_q      <= 1'b0;
      pass_q      <= 1'b0;
      seen_q      <= 1'b0;
      best_q      <= '0;
      out_valid_q <= 1'b0;
      out_sig_q   <= '0;
      out_any_q   <= 1'b0;
      ppx_q <= '0; ppy_q <= '0; ppz_q <= '0;
      jx_q  <= '0; jy_q  <= '0; jz_q  <= '0;
      pcxx_q <= '0; pcxy_q <= '0; pcxz_q <= '0;
      pcyy_q <= '0; pcyz_q <= '0; pczz_q <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            unique case (operation_i)
              mvds_pkg::OP_PRI: begin
                ppx_q  <= pos_x_i;  ppy_q  <= pos_y_i;  ppz_q  <= pos_z_i;
                pcxx_q <= cov_xx_i; pcxy_q <= cov_xy_i; pcxz_q <= cov_xz_i;
                pcyy_q <= cov_yy_i; pcyz_q <= cov_yz_i; pczz_q <= cov_zz_i;
              end
              mvds_pkg::OP_JET: begin
                jx_q <= pos_x_i; jy_q <= pos_y_i; jz_q <= pos_z_i;
              end
              mvds_pkg::OP_SEC: begin
                step_q  <= '0;
                last_q  <= last_i;
                state_q <= S_MUL_GO;
              end
              default: ;
            endcase
          end
        end
        S_MUL_GO: state_q <= S_MUL_WAIT;
        S_MUL_WAIT: begin
          if (mul_done) begin
            if (step_q == mvds_pkg::LAST_STEP) begin
              state_q <= S_CHECK;
            end else begin
              step_q  <= step_q + 1'b1;
              state_q <= S_MUL_GO;
            end
          end
        end
        S_CHECK: begin
          pass_q  <= pass;
          state_q <= pass ? S_ROOT_WAIT : S_FINISH;
        end
        S_ROOT_WAIT: begin
          if (root_done) begin
            sval_q  <= sval;
            state_q <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (!last_q) begin
            best_q  <= best_new;
            seen_q  <= seen_new;
            state_q <= S_IDLE;
          end else if (out_load) begin
            out_sig_q   <= seen_new ? best_new : '0;
            out_any_q   <= seen_new;
            best_q      <= '0;
            seen_q      <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // vertex datapath
  always_ff @(posedge clk_i) begin
    if (in_acc && (operation_i == mvds_pkg::OP_SEC)) begin
      d0_q <= mvds_pkg::DW'(pos_x_i) - mvds_pkg::DW'(ppx_q);
      d1_q <= mvds_pkg::DW'(pos_y_i) - mvds_pkg::DW'(ppy_q);
      d2_q <= mvds_pkg::DW'(pos_z_i) - mvds_pkg::DW'(ppz_q);
      c0_q <= mvds_pkg::CW'(cov_xx_i) + mvds_pkg::CW'(pcxx_q);
      c1_q <= mvds_pkg::CW'(cov_xy_i) + mvds_pkg::CW'(pcxy_q);
      c2_q <= mvds_pkg::CW'(cov_xz_i) + mvds_pkg::CW'(pcxz_q);
      c3_q <= mvds_pkg::CW'(cov_yy_i) + mvds_pkg::CW'(pcyy_q);
      c4_q <= mvds_pkg::CW'(cov_yz_i) + mvds_pkg::CW'(pcyz_q);
      c5_q <= mvds_pkg::CW'(cov_zz_i) + mvds_pkg::CW'(pczz_q);
    end
    if ((state_q == S_MUL_WAIT) && mul_done) begin
      if (stp.op == mvds_pkg::ACC_T) begin
        t_q <= mvds_pkg::TW'(mul_p);
      end
      acc_q <= acc_new;
      unique case (stp.dst)
        mvds_pkg::DST_NONE: ;
        mvds_pkg::DST_DOT:  dotneg_q <= acc_new[mvds_pkg::ACCW-1];
        mvds_pkg::DST_A00:  a00_q <= mvds_pkg::AW'(acc_new);
        mvds_pkg::DST_A11:  a11_q <= mvds_pkg::AW'(acc_new);
        mvds_pkg::DST_A22:  a22_q <= mvds_pkg::AW'(acc_new);
        mvds_pkg::DST_A01:  a01_q <= mvds_pkg::AW'(acc_new);
        mvds_pkg::DST_A02:  a02_q <= mvds_pkg::AW'(acc_new);
        mvds_pkg::DST_A12:  a12_q <= mvds_pkg::AW'(acc_new);
        mvds_pkg::DST_DET:  det_q <= mvds_pkg::DETW'(acc_new);
        default: ;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign significance_o = out_sig_q;
  assign any_valid_o    = out_any_q;

endmodule

[hw/rtl/mvds_checker.sv]
`timescale 1ns / 1ps

module mvds_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_stall_o,
  input logic [1:0]                       operation_i,
  input logic                             out_valid_o,
  input logic                             out_stall_i,
  input logic [mvds_pkg::SIGW-1:0]        significance_o,
  input logic                             any_valid_o
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(significance_o)
                                   && $stable(any_valid_o))
    else $error("stalled result changed");

  // empty run reports zero
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !any_valid_o |-> significance_o == '0)
    else $error("empty run with nonzero significance");

  // magnitude is saturated before the sign
  a_no_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> significance_o != {1'b1, {(mvds_pkg::SIGW-1){1'b0}}})
    else $error("significance outside symmetric range");

  // a secondary vertex keeps the block busy
  a_sec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && operation_i == mvds_pkg::OP_SEC |=> in_stall_o)
    else $error("secondary vertex did not occupy the sequencer");

endmodule

bind max_vertex_decay_significance mvds_checker u_mvds_checker (.*);

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 60000;
  localparam int DRAIN_CYCLES = 3000;
  localparam int RANDOM_ITEMS = 830;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [1:0] op;
    logic [31:0] pos [3];
    logic [31:0] cov [6];
    logic last;
  } vertex_item_t;

  typedef struct {
    logic [31:0] sig;
    logic any;
  } sig_result_t;

  // scoreboard: significance predictor and queue of expected results
  class sig_scoreboard;
    logic [31:0] pri_pos [3];
    logic [31:0] pri_cov [6];
    logic [31:0] jet [3];
    logic [31:0] best_sig;
    logic seen;
    sig_result_t expected_q [$];

    function new();
      foreach (pri_pos[i]) pri_pos[i] = '0;
      foreach (pri_cov[i]) pri_cov[i] = '0;
      foreach (jet[i]) jet[i] = '0;
      best_sig = '0;
      seen = 1'b0;
    endfunction

    function automatic wide_t sx(logic [31:0] v);
      return wide_t'($signed(v));
    endfunction

    function automatic bit agrees(wide_t x, bit neg);
      return (x != 0) && ((x < 0) == neg);
    endfunction

    function automatic wide_t wabs(wide_t x);
      return (x < 0) ? -x : x;
    endfunction

    // significance of one secondary vertex, returns 0 when it is skipped
    function automatic bit vertex_sig(vertex_item_t it, output logic [31:0] s);
      wide_t d [3];
      wide_t c [6];
      wide_t a00, a11, a22, a01, a02, a12, det, q, n, m, dot, lhs;
      logic [31:0] t;
      bit dneg;
      s = '0;
      for (int i = 0; i < 3; i++) d[i] = sx(it.pos[i]) - sx(pri_pos[i]);
      for (int i = 0; i < 6; i++) c[i] = sx(it.cov[i]) + sx(pri_cov[i]);
      a00 = c[3] * c[5] - c[4] * c[4];
      a11 = c[0] * c[5] - c[2] * c[2];
      a22 = c[0] * c[3] - c[1] * c[1];
      a01 = c[2] * c[4] - c[1] * c[5];
      a02 = c[1] * c[4] - c[2] * c[3];
      a12 = c[1] * c[2] - c[0] * c[4];
      det = c[0] * a00 + c[1] * a01 + c[2] * a02;
      if (det == 0) return 0;
      dneg = det < 0;
      if (!agrees(a00, dneg) || !agrees(a11, dneg) || !agrees(a22, dneg)) return 0;
      q = a00 * d[0] * d[0] + a11 * d[1] * d[1] + a22 * d[2] * d[2]
        + 2 * (a01 * d[0] * d[1] + a02 * d[0] * d[2] + a12 * d[1] * d[2]);
      if (!agrees(q, dneg)) return 0;
      n = wabs(q) <<< 24;
      m = wabs(det);
      for (int b = 30; b >= 0; b--) begin
        t = s | (32'd1 << b);
        lhs = wide_t'(t) * wide_t'(t) * m;
        if (lhs <= n) s = t;
      end
      dot = d[0] * sx(jet[0]) + d[1] * sx(jet[1]) + d[2] * sx(jet[2]);
      if (dot < 0) s = -s;
      return 1;
    endfunction

    // accepted input transaction
    function void note(vertex_item_t it);
      logic [31:0] s;
      sig_result_t r;
      unique case (it.op)
        mvds_pkg::OP_PRI: begin
          pri_pos = it.pos;
          pri_cov = it.cov;
        end
        mvds_pkg::OP_JET: jet = it.pos;
        mvds_pkg::OP_SEC: begin
          if (vertex_sig(it, s)) begin
            if (!seen || $signed(s) > $signed(best_sig)) best_sig = s;
            seen = 1'b1;
          end
          if (it.last) begin
            r.sig = seen ? best_sig : '0;
            r.any = seen;
            expected_q.insert(expected_q.size(), r);
            best_sig = '0;
            seen = 1'b0;
          end
        end
        default: ;
      endcase
    endfunction

    // accepted output transaction, returns an empty string when it matches
    function string check(logic [31:0] sig, logic any);
      sig_result_t e;
      if (expected_q.size() == 0)
        return $sformatf("unexpected result sig=%0h any=%0b", sig, any);
      e = expected_q.pop_front();
      if (sig !== e.sig || any !== e.any)
        return $sformatf("result sig=%0h any=%0b, expected sig=%0h any=%0b",
                         sig, any, e.sig, e.any);
      return "";
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] operation_i = '0;
  logic signed [mvds_pkg::POS_WIDTH-1:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic signed [mvds_pkg::COV_WIDTH-1:0] cov_xx_i = '0, cov_xy_i = '0, cov_xz_i = '0;
  logic signed [mvds_pkg::COV_WIDTH-1:0] cov_yy_i = '0, cov_yz_i = '0, cov_zz_i = '0;
  logic last_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [mvds_pkg::SIGW-1:0] significance_o;
  logic any_valid_o;

  sig_scoreboard sb = new();
  int fail_count = 0;
  int idle_cycles = 0;
  bit quiet = 1'b0;

  max_vertex_decay_significance uut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report(string msg);
    $display("mismatch: %s", msg);
    fail_count++;
  endtask

  function automatic int gap_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(20, 150);
  endfunction

  // drive one input transaction and wait for acceptance
  task automatic send(vertex_item_t it);
    repeat (gap_len()) @(negedge clk_i);
    in_valid_i = 1'b1;
    operation_i = it.op;
    {pos_x_i, pos_y_i, pos_z_i} = {it.pos[0], it.pos[1], it.pos[2]};
    {cov_xx_i, cov_xy_i, cov_xz_i} = {it.cov[0], it.cov[1], it.cov[2]};
    {cov_yy_i, cov_yz_i, cov_zz_i} = {it.cov[3], it.cov[4], it.cov[5]};
    last_i = it.last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note(it);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  function automatic vertex_item_t noise_item();
    vertex_item_t it;
    it.op = 2'($urandom_range(0, 3));
    foreach (it.pos[i]) it.pos[i] = $urandom;
    foreach (it.cov[i]) it.cov[i] = $urandom;
    it.last = 1'($urandom_range(0, 1));
    return it;
  endfunction

  // well-formed vertex: positive diagonal, smaller off-diagonal terms, now and then one random term
  function automatic vertex_item_t make_vertex(logic [1:0] op, logic [31:0] base [3]);
    vertex_item_t it;
    int span;
    int off;
    span = ($urandom_range(0, 9) == 0) ? 30 : $urandom_range(4, 22);
    it.op = op;
    foreach (it.pos[i]) begin
      off = $signed($urandom) >>> (31 - span);
      it.pos[i] = base[i] + off;
    end
    it.cov[0] = $urandom_range(1, 1 << 22);
    it.cov[3] = $urandom_range(1, 1 << 22);
    it.cov[5] = $urandom_range(1, 1 << 22);
    it.cov[1] = $signed($urandom) >>> 12;
    it.cov[2] = $signed($urandom) >>> 12;
    it.cov[4] = $signed($urandom) >>> 12;
    if ($urandom_range(0, 15) == 0) it.cov[$urandom_range(0, 5)] = $urandom;
    it.last = 1'b0;
    return it;
  endfunction

  function automatic vertex_item_t filled(logic [1:0] op, logic [31:0] p, logic [31:0] c,
                                          logic lst);
    vertex_item_t it;
    it.op = op;
    foreach (it.pos[i]) it.pos[i] = p;
    foreach (it.cov[i]) it.cov[i] = c;
    it.last = lst;
    return it;
  endfunction

  // output side: random stall, check each accepted result
  always @(negedge clk_i) begin
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) out_stall_i <= 1'b0;
    else if (r < 97) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      msg = sb.check(significance_o, any_valid_o);
      if (msg != "") report(msg);
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAIL max_vertex_decay_significance");
      $finish;
    end
  end

  initial begin
    vertex_item_t it;
    logic [31:0] origin [3];
    logic [31:0] pv [3];
    int sent;
    int nsec;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: reset state, extremes, unused code, stray last flags
    send(filled(mvds_pkg::OP_SEC, 32'h0001_0000, 32'h0000_1000, 1'b1));
    send(filled(mvds_pkg::OP_SEC, 32'h7fff_ffff, 32'h7fff_ffff, 1'b1));
    send(filled(mvds_pkg::OP_SEC, 32'h8000_0000, 32'h8000_0000, 1'b1));
    send(filled(OP_UNUSED, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    send(filled(mvds_pkg::OP_PRI, 32'h0, 32'h0, 1'b1));
    send(filled(mvds_pkg::OP_JET, 32'h0, 32'h0, 1'b1));
    // zero jet direction, singular covariance, zero offset
    origin = '{32'h0, 32'h0, 32'h0};
    it = make_vertex(mvds_pkg::OP_SEC, origin);
    send(it);
    send(filled(mvds_pkg::OP_SEC, 32'h0, 32'h0, 1'b0));
    it.pos = origin;
    it.last = 1'b1;
    send(it);
    // jet against and along the offset, saturating significance
    send(filled(mvds_pkg::OP_JET, 32'hffff_0000, 32'h0, 1'b0));
    it = make_vertex(mvds_pkg::OP_SEC, origin);
    it.pos = '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
    it.cov = '{32'd1, 32'd0, 32'd0, 32'd1, 32'd0, 32'd1};
    it.last = 1'b1;
    send(it);
    it.pos = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
    send(it);
    // negative definite sum and primary at extremes
    send(filled(mvds_pkg::OP_PRI, 32'h8000_0000, 32'hffff_0000, 1'b0));
    it.cov = '{32'hffff_fff0, 32'd0, 32'd0, 32'hffff_fff0, 32'd0, 32'hffff_fff0};
    it.pos = '{32'h7fff_ffff, 32'h0, 32'h1};
    send(it);
    send(filled(mvds_pkg::OP_PRI, 32'h7fff_ffff, 32'h7fff_ffff, 1'b0));
    it.pos = '{32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff};
    it.cov = '{32'h7fff_ffff, 32'h0, 32'h0, 32'h7fff_ffff, 32'h0, 32'h7fff_ffff};
    send(it);

    // random: mostly well-formed events, some noise
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent % 120 == 0) quiet = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 9) < 8) begin
        foreach (pv[i]) pv[i] = $signed($urandom) >>> $urandom_range(0, 12);
        if ($urandom_range(0, 2) != 0) begin
          it = make_vertex(mvds_pkg::OP_PRI, pv);
          foreach (it.pos[i]) it.pos[i] = pv[i];
          send(it);
          sent++;
        end
        if ($urandom_range(0, 2) != 0) begin
          it = noise_item();
          it.op = mvds_pkg::OP_JET;
          if ($urandom_range(0, 9) == 0) it.pos = '{32'h0, 32'h0, 32'h0};
          send(it);
          sent++;
        end
        nsec = $urandom_range(1, 4);
        for (int k = 0; k < nsec; k++) begin
          it = make_vertex(mvds_pkg::OP_SEC, sb.pri_pos);
          it.last = (k == nsec - 1);
          send(it);
          sent++;
        end
      end else begin
        send(noise_item());
        sent++;
      end
    end
    quiet = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && sb.expected_q.size() == 0) begin
      $display("PASS max_vertex_decay_significance");
    end else begin
      $display("FAIL max_vertex_decay_significance");
    end
    $finish;
  end

endmodule

[max_vertex_decay_significance.f]
hw/rtl/mvds_pkg.sv
hw/rtl/mvds_mul.sv
hw/rtl/mvds_root.sv
hw/rtl/max_vertex_decay_significance.sv
hw/rtl/mvds_checker.sv
bench/tb.sv
